@@ hdl/dwql_pkg.sv @@
// Shared widths, constants and command codes of the dual-window quota limiter.
package dwql_pkg;

    // Field widths
    localparam int unsigned CNT_W     = 24;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned AMT_W     = 16;
    localparam int unsigned SEC_W     = 17;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // Pool ceiling for saturating restore
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Window gaps in seconds
    localparam logic [TIME_W-1:0] MINUTE_GAP  = 32'd50;
    localparam logic [TIME_W-1:0] DAY_GAP     = 32'd86300;
    localparam logic [SEC_W-1:0]  DAY_SECONDS = 17'd86400;

    // Second of day: 86400 = 2^7 * 675.
    // The low 7 bits pass straight through; the upper part is reduced mod 675
    // by a reciprocal multiply, exact for every 25-bit operand.
    localparam int unsigned DAY_LOW_W  = 7;
    localparam int unsigned Q_W        = TIME_W - DAY_LOW_W;
    localparam int unsigned MULT_W     = 26;
    localparam int unsigned PROD_W     = Q_W + MULT_W;
    localparam int unsigned DIV_SHIFT  = 35;
    localparam int unsigned QUOT_W     = 16;
    localparam int unsigned REM_W      = 10;
    localparam logic [MULT_W-1:0] DIV_MULT = 26'd50903317;
    localparam logic [REM_W-1:0]  DAY_ODD  = 10'd675;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_REQ_NORM  = 3'd1,
        CMD_REQ_ACT   = 3'd2,
        CMD_RESTORE   = 3'd3,
        CMD_SET_DAILY = 3'd4,
        CMD_REINIT    = 3'd5
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DAY_LIMIT   = 3'd0,
        CFG_MIN_LIMIT   = 3'd1,
        CFG_ACTIVE_CAP  = 3'd2,
        CFG_PAUSE_START = 3'd3,
        CFG_PAUSE_END   = 3'd4
    } cfg_idx_t;

endpackage

@@ hdl/dual_window_quota_limiter.sv @@
// Pipeline: input register, post-step snapshot and result register; out_valid comes from the result register.
// Throughput: one item per cycle unless out_ready stalls it; pool state is updated in the
// first stage, so each item sees the pools left by the one before it with no extra wait.
// Bubbles collapse: new items are taken while a finished result waits for its transfer.
// Reset (rst_n low, asynchronous) clears all pools, totals, window starts, configuration
// registers and pipeline valid flags.
module dual_window_quota_limiter (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dwql_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dwql_pkg::CNT_W-1:0]    cfg_data,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dwql_pkg::CMD_W-1:0]    cmd,
    input  logic [dwql_pkg::TIME_W-1:0]   now_time,
    input  logic [dwql_pkg::AMT_W-1:0]    amount,
    input  logic                          vip,
    input  logic [dwql_pkg::TIME_W-1:0]   saved_day_time,
    input  logic [dwql_pkg::TIME_W-1:0]   saved_count,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dwql_pkg::AMT_W-1:0]    granted,
    output logic                          has_quota,
    output logic                          has_active_quota,
    output logic                          busy_res,
    output logic [dwql_pkg::CNT_W-1:0]    daily_remaining,
    output logic [dwql_pkg::CNT_W-1:0]    minute_remaining,
    output logic [dwql_pkg::CNT_W-1:0]    active_remaining,
    output logic [dwql_pkg::TIME_W-1:0]   active_day_total,
    output logic [dwql_pkg::TIME_W-1:0]   vip_minute_used,
    output logic [dwql_pkg::TIME_W-1:0]   vip_day_used,
    output logic [dwql_pkg::TIME_W-1:0]   day_window_start
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dwql_pkg::CNT_W-1:0] day_limit_reg;
    logic [dwql_pkg::CNT_W-1:0] min_limit_reg;
    logic [dwql_pkg::CNT_W-1:0] active_cap_reg;
    logic [dwql_pkg::SEC_W-1:0] pause_start_reg;
    logic [dwql_pkg::SEC_W-1:0] pause_end_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_limit_reg   <= '0;
            min_limit_reg   <= '0;
            active_cap_reg  <= '0;
            pause_start_reg <= '0;
            pause_end_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dwql_pkg::CFG_DAY_LIMIT:   day_limit_reg   <= cfg_data;
                dwql_pkg::CFG_MIN_LIMIT:   min_limit_reg   <= cfg_data;
                dwql_pkg::CFG_ACTIVE_CAP:  active_cap_reg  <= cfg_data;
                dwql_pkg::CFG_PAUSE_START: pause_start_reg <= cfg_data[dwql_pkg::SEC_W-1:0];
                dwql_pkg::CFG_PAUSE_END:   pause_end_reg   <= cfg_data[dwql_pkg::SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage moves when the one after it is free or moving
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic en1, en2, en3;
    logic s1_fire;

    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign s1_fire  = s1_valid_reg && en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [dwql_pkg::CMD_W-1:0]  s1_cmd_reg;
    logic [dwql_pkg::TIME_W-1:0] s1_now_reg;
    logic [dwql_pkg::AMT_W-1:0]  s1_amt_reg;
    logic                        s1_vip_reg;
    logic [dwql_pkg::TIME_W-1:0] s1_sday_reg;
    logic [dwql_pkg::TIME_W-1:0] s1_scnt_reg;

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_cmd_reg  <= cmd;
            s1_now_reg  <= now_time;
            s1_amt_reg  <= amount;
            s1_vip_reg  <= vip;
            s1_sday_reg <= saved_day_time;
            s1_scnt_reg <= saved_count;
        end
    end

    // ------------------------------------------------------------------
    // Limiter state
    // ------------------------------------------------------------------
    logic [dwql_pkg::CNT_W-1:0]  daily_left_reg,  daily_left_next;
    logic [dwql_pkg::CNT_W-1:0]  minute_left_reg, minute_left_next;
    logic [dwql_pkg::CNT_W-1:0]  active_left_reg, active_left_next;
    logic [dwql_pkg::TIME_W-1:0] active_total_day_reg, active_total_day_next;
    logic [dwql_pkg::TIME_W-1:0] vip_total_minute_reg, vip_total_minute_next;
    logic [dwql_pkg::TIME_W-1:0] vip_total_day_reg,    vip_total_day_next;
    logic [dwql_pkg::TIME_W-1:0] minute_window_start_reg, minute_window_start_next;
    logic [dwql_pkg::TIME_W-1:0] day_window_begin_reg,    day_window_begin_next;
    logic [dwql_pkg::AMT_W-1:0]  s2_granted_next;

    // Stage 1 helpers
    logic [dwql_pkg::CNT_W-1:0]  s1_amt_ext;
    logic [dwql_pkg::TIME_W-1:0] s1_amt_wide;
    logic [dwql_pkg::TIME_W-1:0] min_elapsed;
    logic [dwql_pkg::TIME_W-1:0] day_elapsed;
    logic                        norm_ok;
    logic                        act_ok;
    logic [dwql_pkg::CNT_W:0]    daily_sum;
    logic [dwql_pkg::CNT_W:0]    minute_sum;
    logic [dwql_pkg::TIME_W-1:0] day_limit_wide;

    assign s1_amt_ext     = dwql_pkg::CNT_W'(s1_amt_reg);
    assign s1_amt_wide    = dwql_pkg::TIME_W'(s1_amt_reg);
    assign min_elapsed    = s1_now_reg - minute_window_start_reg;
    assign day_elapsed    = s1_now_reg - day_window_begin_reg;
    assign norm_ok        = (daily_left_reg >= s1_amt_ext) && (minute_left_reg >= s1_amt_ext);
    assign act_ok         = active_left_reg >= s1_amt_ext;
    assign daily_sum      = {1'b0, daily_left_reg} + {1'b0, s1_amt_ext};
    assign minute_sum     = {1'b0, minute_left_reg} + {1'b0, s1_amt_ext};
    assign day_limit_wide = dwql_pkg::TIME_W'(day_limit_reg);

    // Command decode and next state
    always_comb
    begin
        daily_left_next          = daily_left_reg;
        minute_left_next         = minute_left_reg;
        active_left_next         = active_left_reg;
        active_total_day_next    = active_total_day_reg;
        vip_total_minute_next    = vip_total_minute_reg;
        vip_total_day_next       = vip_total_day_reg;
        minute_window_start_next = minute_window_start_reg;
        day_window_begin_next    = day_window_begin_reg;
        s2_granted_next          = '0;

        unique case (s1_cmd_reg)
            dwql_pkg::CMD_TICK:
            begin
                if (min_elapsed > dwql_pkg::MINUTE_GAP)
                begin
                    minute_left_next         = min_limit_reg;
                    active_left_next         = active_cap_reg;
                    vip_total_minute_next    = '0;
                    minute_window_start_next = s1_now_reg;
                end
                if (day_elapsed > dwql_pkg::DAY_GAP)
                begin
                    daily_left_next       = day_limit_reg;
                    active_total_day_next = '0;
                    vip_total_day_next    = '0;
                    day_window_begin_next = s1_now_reg;
                end
            end
            dwql_pkg::CMD_REQ_NORM:
            begin
                if (norm_ok)
                begin
                    daily_left_next  = daily_left_reg - s1_amt_ext;
                    minute_left_next = minute_left_reg - s1_amt_ext;
                    s2_granted_next  = s1_amt_reg;
                end
            end
            dwql_pkg::CMD_REQ_ACT:
            begin
                if (act_ok)
                begin
                    active_left_next      = active_left_reg - s1_amt_ext;
                    active_total_day_next = active_total_day_reg + s1_amt_wide;
                    if (s1_vip_reg)
                    begin
                        vip_total_day_next    = vip_total_day_reg + s1_amt_wide;
                        vip_total_minute_next = vip_total_minute_reg + s1_amt_wide;
                    end
                    s2_granted_next = s1_amt_reg;
                end
            end
            dwql_pkg::CMD_RESTORE:
            begin
                // saturate at the pool ceiling
                daily_left_next  = daily_sum[dwql_pkg::CNT_W] ? dwql_pkg::CNT_MAX
                                                              : daily_sum[dwql_pkg::CNT_W-1:0];
                minute_left_next = minute_sum[dwql_pkg::CNT_W] ? dwql_pkg::CNT_MAX
                                                               : minute_sum[dwql_pkg::CNT_W-1:0];
            end
            dwql_pkg::CMD_SET_DAILY:
            begin
                daily_left_next = (s1_scnt_reg > day_limit_wide)
                                ? day_limit_reg : s1_scnt_reg[dwql_pkg::CNT_W-1:0];
                day_window_begin_next = s1_sday_reg;
            end
            dwql_pkg::CMD_REINIT:
            begin
                daily_left_next          = day_limit_reg;
                minute_left_next         = min_limit_reg;
                minute_window_start_next = s1_now_reg;
                day_window_begin_next    = s1_now_reg;
                active_left_next         = '0;
                active_total_day_next    = '0;
                vip_total_minute_next    = '0;
                vip_total_day_next       = '0;
            end
            default: ;
        endcase
    end

    // State update as the item leaves stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            daily_left_reg          <= '0;
            minute_left_reg         <= '0;
            active_left_reg         <= '0;
            active_total_day_reg    <= '0;
            vip_total_minute_reg    <= '0;
            vip_total_day_reg       <= '0;
            minute_window_start_reg <= '0;
            day_window_begin_reg    <= '0;
        end
        else if (s1_fire)
        begin
            daily_left_reg          <= daily_left_next;
            minute_left_reg         <= minute_left_next;
            active_left_reg         <= active_left_next;
            active_total_day_reg    <= active_total_day_next;
            vip_total_minute_reg    <= vip_total_minute_next;
            vip_total_day_reg       <= vip_total_day_next;
            minute_window_start_reg <= minute_window_start_next;
            day_window_begin_reg    <= day_window_begin_next;
        end
    end

    // Quotient of (now >> 7) / 675 by reciprocal multiply
    logic [dwql_pkg::PROD_W-1:0] s1_div_prod;

    assign s1_div_prod = dwql_pkg::PROD_W'(s1_now_reg[dwql_pkg::TIME_W-1:dwql_pkg::DAY_LOW_W])
                       * dwql_pkg::PROD_W'(dwql_pkg::DIV_MULT);

    // ------------------------------------------------------------------
    // Stage 2: post-step snapshot and partial second-of-day
    // ------------------------------------------------------------------
    logic [dwql_pkg::AMT_W-1:0]     s2_granted_reg;
    logic [dwql_pkg::AMT_W-1:0]     s2_amt_reg;
    logic [dwql_pkg::CNT_W-1:0]     s2_daily_reg;
    logic [dwql_pkg::CNT_W-1:0]     s2_minute_reg;
    logic [dwql_pkg::CNT_W-1:0]     s2_active_reg;
    logic [dwql_pkg::TIME_W-1:0]    s2_act_total_reg;
    logic [dwql_pkg::TIME_W-1:0]    s2_vip_min_reg;
    logic [dwql_pkg::TIME_W-1:0]    s2_vip_day_reg;
    logic [dwql_pkg::TIME_W-1:0]    s2_day_begin_reg;
    logic [dwql_pkg::Q_W-1:0]       s2_q_reg;
    logic [dwql_pkg::QUOT_W-1:0]    s2_quot_reg;
    logic [dwql_pkg::DAY_LOW_W-1:0] s2_low_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_granted_reg   <= s2_granted_next;
            s2_amt_reg       <= s1_amt_reg;
            s2_daily_reg     <= daily_left_next;
            s2_minute_reg    <= minute_left_next;
            s2_active_reg    <= active_left_next;
            s2_act_total_reg <= active_total_day_next;
            s2_vip_min_reg   <= vip_total_minute_next;
            s2_vip_day_reg   <= vip_total_day_next;
            s2_day_begin_reg <= day_window_begin_next;
            s2_q_reg         <= s1_now_reg[dwql_pkg::TIME_W-1:dwql_pkg::DAY_LOW_W];
            s2_quot_reg      <= s1_div_prod[dwql_pkg::DIV_SHIFT +: dwql_pkg::QUOT_W];
            s2_low_reg       <= s1_now_reg[dwql_pkg::DAY_LOW_W-1:0];
        end
    end

    // Remainder mod 675, then second of day
    logic [dwql_pkg::Q_W-1:0]   s2_rem_full;
    logic [dwql_pkg::SEC_W-1:0] s2_sec;
    logic [dwql_pkg::CNT_W-1:0] s2_amt_ext;
    logic                       s2_busy;
    logic                       s2_has_quota;
    logic                       s2_has_act;

    assign s2_rem_full = s2_q_reg - (dwql_pkg::Q_W'(s2_quot_reg) * dwql_pkg::Q_W'(dwql_pkg::DAY_ODD));
    assign s2_sec      = {s2_rem_full[dwql_pkg::REM_W-1:0], s2_low_reg};
    assign s2_amt_ext  = dwql_pkg::CNT_W'(s2_amt_reg);

    // Pool flags after the step
    assign s2_has_quota = (s2_daily_reg >= s2_amt_ext) && (s2_minute_reg >= s2_amt_ext);
    assign s2_has_act   = s2_active_reg >= s2_amt_ext;

    // Pause window, possibly wrapping past midnight
    always_comb
    begin
        priority if (pause_start_reg < pause_end_reg)
            s2_busy = (s2_sec > pause_start_reg) && (s2_sec < pause_end_reg);
        else if (pause_start_reg > pause_end_reg)
            s2_busy = (s2_sec < pause_end_reg) || (s2_sec > pause_start_reg);
        else
            s2_busy = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stage 3: result register
    // ------------------------------------------------------------------
    logic [dwql_pkg::AMT_W-1:0]  s3_granted_reg;
    logic                        s3_has_quota_reg;
    logic                        s3_has_act_reg;
    logic                        s3_busy_reg;
    logic [dwql_pkg::CNT_W-1:0]  s3_daily_reg;
    logic [dwql_pkg::CNT_W-1:0]  s3_minute_reg;
    logic [dwql_pkg::CNT_W-1:0]  s3_active_reg;
    logic [dwql_pkg::TIME_W-1:0] s3_act_total_reg;
    logic [dwql_pkg::TIME_W-1:0] s3_vip_min_reg;
    logic [dwql_pkg::TIME_W-1:0] s3_vip_day_reg;
    logic [dwql_pkg::TIME_W-1:0] s3_day_begin_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_granted_reg   <= s2_granted_reg;
            s3_has_quota_reg <= s2_has_quota;
            s3_has_act_reg   <= s2_has_act;
            s3_busy_reg      <= s2_busy;
            s3_daily_reg     <= s2_daily_reg;
            s3_minute_reg    <= s2_minute_reg;
            s3_active_reg    <= s2_active_reg;
            s3_act_total_reg <= s2_act_total_reg;
            s3_vip_min_reg   <= s2_vip_min_reg;
            s3_vip_day_reg   <= s2_vip_day_reg;
            s3_day_begin_reg <= s2_day_begin_reg;
        end
    end

    assign out_valid        = s3_valid_reg;
    assign granted          = s3_granted_reg;
    assign has_quota        = s3_has_quota_reg;
    assign has_active_quota = s3_has_act_reg;
    assign busy_res         = s3_busy_reg;
    assign daily_remaining  = s3_daily_reg;
    assign minute_remaining = s3_minute_reg;
    assign active_remaining = s3_active_reg;
    assign active_day_total = s3_act_total_reg;
    assign vip_minute_used  = s3_vip_min_reg;
    assign vip_day_used     = s3_vip_day_reg;
    assign day_window_start = s3_day_begin_reg;

`ifndef SYNTHESIS
    // State only moves when an item leaves stage 1
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(daily_left_reg) && $stable(active_left_reg)
                     && $stable(day_window_begin_reg))
        else $error("limiter state changed with no item in update");

    // A granted normal request debits both pools by the amount
    a_norm_debit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_cmd_reg == dwql_pkg::CMD_REQ_NORM) && norm_ok
        |=> (daily_left_reg == $past(daily_left_reg) - $past(s1_amt_ext))
            && (minute_left_reg == $past(minute_left_reg) - $past(s1_amt_ext)))
        else $error("normal grant did not debit both pools");

    // A restored daily point never exceeds the daily cap
    a_set_day_limit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_cmd_reg == dwql_pkg::CMD_SET_DAILY)
        |=> daily_left_reg <= $past(day_limit_reg))
        else $error("daily point above cap");

    // Second-of-day reduction stays inside one day
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> s2_sec < dwql_pkg::DAY_SECONDS)
        else $error("second of day out of range");
`endif

endmodule

@@ tb/sv/tb_dual_window_quota_limiter.sv @@
// Self-checking testbench for the dual-window quota limiter: directed and random traffic.
`timescale 1ns / 100ps

// Command codes and a register index that the block does not define
localparam logic [dwql_pkg::CMD_W-1:0]     CMD_SPARE_A = 3'd6;
localparam logic [dwql_pkg::CMD_W-1:0]     CMD_SPARE_B = 3'd7;
localparam logic [dwql_pkg::CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;

typedef struct {
    logic [dwql_pkg::CMD_W-1:0]  cmd;
    logic [dwql_pkg::TIME_W-1:0] now;
    logic [dwql_pkg::AMT_W-1:0]  amt;
    logic                        vip;
    logic [dwql_pkg::TIME_W-1:0] sday;
    logic [dwql_pkg::TIME_W-1:0] scnt;
} quota_req_t;

typedef struct {
    logic [dwql_pkg::AMT_W-1:0]  granted;
    logic                        has_quota;
    logic                        has_active_quota;
    logic                        busy;
    logic [dwql_pkg::CNT_W-1:0]  daily_left;
    logic [dwql_pkg::CNT_W-1:0]  minute_left;
    logic [dwql_pkg::CNT_W-1:0]  active_left;
    logic [dwql_pkg::TIME_W-1:0] active_day_sum;
    logic [dwql_pkg::TIME_W-1:0] vip_minute_sum;
    logic [dwql_pkg::TIME_W-1:0] vip_day_sum;
    logic [dwql_pkg::TIME_W-1:0] day_start;
} quota_res_t;

// Scoreboard: mirrors the pools and windows, holds the awaited results in order
class quota_ledger;
    logic [dwql_pkg::CNT_W-1:0]  day_limit      = '0;
    logic [dwql_pkg::CNT_W-1:0]  min_limit      = '0;
    logic [dwql_pkg::CNT_W-1:0]  active_cap     = '0;
    logic [dwql_pkg::SEC_W-1:0]  pause_open     = '0;
    logic [dwql_pkg::SEC_W-1:0]  pause_close    = '0;
    logic [dwql_pkg::CNT_W-1:0]  daily_pool     = '0;
    logic [dwql_pkg::CNT_W-1:0]  minute_pool    = '0;
    logic [dwql_pkg::CNT_W-1:0]  active_pool    = '0;
    logic [dwql_pkg::TIME_W-1:0] active_sum_day = '0;
    logic [dwql_pkg::TIME_W-1:0] vip_sum_minute = '0;
    logic [dwql_pkg::TIME_W-1:0] vip_sum_day    = '0;
    logic [dwql_pkg::TIME_W-1:0] minute_begin   = '0;
    logic [dwql_pkg::TIME_W-1:0] day_begin      = '0;
    quota_res_t                  awaited[$];
    int unsigned                 errors = 0;
    int unsigned                 checked = 0;
    int unsigned                 grants = 0;

    function void write_reg(logic [dwql_pkg::CFG_IDX_W-1:0] idx,
                            logic [dwql_pkg::CNT_W-1:0] data);
        case (idx)
            dwql_pkg::CFG_DAY_LIMIT:   day_limit   = data;
            dwql_pkg::CFG_MIN_LIMIT:   min_limit   = data;
            dwql_pkg::CFG_ACTIVE_CAP:  active_cap  = data;
            dwql_pkg::CFG_PAUSE_START: pause_open  = data[dwql_pkg::SEC_W-1:0];
            dwql_pkg::CFG_PAUSE_END:   pause_close = data[dwql_pkg::SEC_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned pending();
        return awaited.size();
    endfunction

    // Work out the result of one accepted input transfer
    function void note_input(quota_req_t r);
        quota_res_t                  e;
        logic [dwql_pkg::TIME_W-1:0] since_min;
        logic [dwql_pkg::TIME_W-1:0] since_day;
        logic [dwql_pkg::TIME_W-1:0] sod;
        e.granted = '0;
        since_min = r.now - minute_begin;
        since_day = r.now - day_begin;
        case (r.cmd)
            dwql_pkg::CMD_TICK:
            begin
                if (since_min > dwql_pkg::MINUTE_GAP)
                begin
                    minute_pool    = min_limit;
                    active_pool    = active_cap;
                    vip_sum_minute = '0;
                    minute_begin   = r.now;
                end
                if (since_day > dwql_pkg::DAY_GAP)
                begin
                    daily_pool     = day_limit;
                    active_sum_day = '0;
                    vip_sum_day    = '0;
                    day_begin      = r.now;
                end
            end
            dwql_pkg::CMD_REQ_NORM:
            begin
                if (daily_pool >= r.amt && minute_pool >= r.amt)
                begin
                    daily_pool  = daily_pool - r.amt;
                    minute_pool = minute_pool - r.amt;
                    e.granted   = r.amt;
                end
            end
            dwql_pkg::CMD_REQ_ACT:
            begin
                if (active_pool >= r.amt)
                begin
                    active_pool    = active_pool - r.amt;
                    active_sum_day = active_sum_day + r.amt;
                    if (r.vip)
                    begin
                        vip_sum_day    = vip_sum_day + r.amt;
                        vip_sum_minute = vip_sum_minute + r.amt;
                    end
                    e.granted = r.amt;
                end
            end
            dwql_pkg::CMD_RESTORE:
            begin
                // both pools saturate at the counter ceiling
                daily_pool  = (dwql_pkg::CNT_MAX - daily_pool < r.amt)
                            ? dwql_pkg::CNT_MAX : daily_pool + r.amt;
                minute_pool = (dwql_pkg::CNT_MAX - minute_pool < r.amt)
                            ? dwql_pkg::CNT_MAX : minute_pool + r.amt;
            end
            dwql_pkg::CMD_SET_DAILY:
            begin
                daily_pool = (r.scnt > dwql_pkg::TIME_W'(day_limit))
                           ? day_limit : r.scnt[dwql_pkg::CNT_W-1:0];
                day_begin  = r.sday;
            end
            dwql_pkg::CMD_REINIT:
            begin
                daily_pool     = day_limit;
                minute_pool    = min_limit;
                minute_begin   = r.now;
                day_begin      = r.now;
                active_pool    = '0;
                active_sum_day = '0;
                vip_sum_minute = '0;
                vip_sum_day    = '0;
            end
            default: ;
        endcase
        e.has_quota        = (daily_pool >= r.amt) && (minute_pool >= r.amt);
        e.has_active_quota = active_pool >= r.amt;
        // pause window, open strictly inside, may wrap past midnight
        sod = r.now % dwql_pkg::TIME_W'(dwql_pkg::DAY_SECONDS);
        if (pause_open < pause_close)
            e.busy = (sod > pause_open) && (sod < pause_close);
        else if (pause_open > pause_close)
            e.busy = (sod < pause_close) || (sod > pause_open);
        else
            e.busy = 1'b0;
        e.daily_left     = daily_pool;
        e.minute_left    = minute_pool;
        e.active_left    = active_pool;
        e.active_day_sum = active_sum_day;
        e.vip_minute_sum = vip_sum_minute;
        e.vip_day_sum    = vip_sum_day;
        e.day_start      = day_begin;
        awaited.push_back(e);
    endfunction

    function void compare_field(string name, logic [dwql_pkg::TIME_W-1:0] want,
                                logic [dwql_pkg::TIME_W-1:0] seen);
        if (want !== seen)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        end
    endfunction

    // Compare one result transfer with the oldest awaited result
    function void check_result(quota_res_t got);
        quota_res_t e;
        if (awaited.size() == 0)
        begin
            errors++;
            $display("%0t: result with none awaited, expected nothing, actual granted %0h",
                     $time, got.granted);
            return;
        end
        e = awaited.pop_front();
        checked++;
        if (got.granted != '0)
            grants++;
        compare_field("granted", dwql_pkg::TIME_W'(e.granted),
                      dwql_pkg::TIME_W'(got.granted));
        compare_field("has_quota", dwql_pkg::TIME_W'(e.has_quota),
                      dwql_pkg::TIME_W'(got.has_quota));
        compare_field("has_active_quota", dwql_pkg::TIME_W'(e.has_active_quota),
                      dwql_pkg::TIME_W'(got.has_active_quota));
        compare_field("busy_res", dwql_pkg::TIME_W'(e.busy), dwql_pkg::TIME_W'(got.busy));
        compare_field("daily_remaining", dwql_pkg::TIME_W'(e.daily_left),
                      dwql_pkg::TIME_W'(got.daily_left));
        compare_field("minute_remaining", dwql_pkg::TIME_W'(e.minute_left),
                      dwql_pkg::TIME_W'(got.minute_left));
        compare_field("active_remaining", dwql_pkg::TIME_W'(e.active_left),
                      dwql_pkg::TIME_W'(got.active_left));
        compare_field("active_day_total", e.active_day_sum, got.active_day_sum);
        compare_field("vip_minute_used", e.vip_minute_sum, got.vip_minute_sum);
        compare_field("vip_day_used", e.vip_day_sum, got.vip_day_sum);
        compare_field("day_window_start", e.day_start, got.day_start);
    endfunction
endclass

module tb_dual_window_quota_limiter;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 120;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [dwql_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dwql_pkg::CNT_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [dwql_pkg::CMD_W-1:0]     cmd;
    logic [dwql_pkg::TIME_W-1:0]    now_time;
    logic [dwql_pkg::AMT_W-1:0]     amount;
    logic                           vip;
    logic [dwql_pkg::TIME_W-1:0]    saved_day_time;
    logic [dwql_pkg::TIME_W-1:0]    saved_count;
    logic                           out_valid;
    logic                           out_ready;
    logic [dwql_pkg::AMT_W-1:0]     granted;
    logic                           has_quota;
    logic                           has_active_quota;
    logic                           busy_res;
    logic [dwql_pkg::CNT_W-1:0]     daily_remaining;
    logic [dwql_pkg::CNT_W-1:0]     minute_remaining;
    logic [dwql_pkg::CNT_W-1:0]     active_remaining;
    logic [dwql_pkg::TIME_W-1:0]    active_day_total;
    logic [dwql_pkg::TIME_W-1:0]    vip_minute_used;
    logic [dwql_pkg::TIME_W-1:0]    vip_day_used;
    logic [dwql_pkg::TIME_W-1:0]    day_window_start;

    quota_ledger                    ledger;
    quota_res_t                     seen_res;
    logic [dwql_pkg::TIME_W-1:0]    cur_time;
    logic [dwql_pkg::AMT_W-1:0]     amt_hi;
    int unsigned                    cycle_count = 0;
    int unsigned                    items_sent = 0;
    int unsigned                    send_idle_pct = 0;
    int unsigned                    stall_pct = 0;
    bit                             long_hold = 0;

    dual_window_quota_limiter u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .now_time         (now_time),
        .amount           (amount),
        .vip              (vip),
        .saved_day_time   (saved_day_time),
        .saved_count      (saved_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .granted          (granted),
        .has_quota        (has_quota),
        .has_active_quota (has_active_quota),
        .busy_res         (busy_res),
        .daily_remaining  (daily_remaining),
        .minute_remaining (minute_remaining),
        .active_remaining (active_remaining),
        .active_day_total (active_day_total),
        .vip_minute_used  (vip_minute_used),
        .vip_day_used     (vip_day_used),
        .day_window_start (day_window_start)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_res.granted          = granted;
            seen_res.has_quota        = has_quota;
            seen_res.has_active_quota = has_active_quota;
            seen_res.busy             = busy_res;
            seen_res.daily_left       = daily_remaining;
            seen_res.minute_left      = minute_remaining;
            seen_res.active_left      = active_remaining;
            seen_res.active_day_sum   = active_day_total;
            seen_res.vip_minute_sum   = vip_minute_used;
            seen_res.vip_day_sum      = vip_day_used;
            seen_res.day_start        = day_window_start;
            ledger.check_result(seen_res);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold  = 0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // One register write; valid stays high across back-to-back writes
    task automatic write_reg(input logic [dwql_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dwql_pkg::CNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ledger.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input logic [dwql_pkg::CNT_W-1:0] dcap, mcap, acap, ps, pe);
        write_reg(dwql_pkg::CFG_DAY_LIMIT, dcap);
        write_reg(dwql_pkg::CFG_MIN_LIMIT, mcap);
        write_reg(dwql_pkg::CFG_ACTIVE_CAP, acap);
        write_reg(dwql_pkg::CFG_PAUSE_START, ps);
        write_reg(dwql_pkg::CFG_PAUSE_END, pe);
        // an undefined index must leave everything alone
        write_reg(CFG_SPARE, dwql_pkg::CNT_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Input transfer with an optional idle burst ahead of it
    task automatic send_item(input quota_req_t r);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= r.cmd;
        now_time       <= r.now;
        amount         <= r.amt;
        vip            <= r.vip;
        saved_day_time <= r.sday;
        saved_count    <= r.scnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ledger.note_input(r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_dir(input logic [dwql_pkg::CMD_W-1:0] c,
                            input logic [dwql_pkg::TIME_W-1:0] t,
                            input logic [dwql_pkg::AMT_W-1:0] a, input logic v,
                            input logic [dwql_pkg::TIME_W-1:0] sd,
                            input logic [dwql_pkg::TIME_W-1:0] sc);
        quota_req_t r;
        r.cmd  = c;
        r.now  = t;
        r.amt  = a;
        r.vip  = v;
        r.sday = sd;
        r.scnt = sc;
        send_item(r);
    endtask

    // Stop offering and let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random item: mostly a clock moving forward with requests and ticks
    task automatic gen_req(output quota_req_t r);
        int unsigned pick;
        int unsigned step_kind;
        step_kind = $urandom_range(0, 99);
        if (step_kind < 65)
            cur_time = cur_time + $urandom_range(0, 12);
        else if (step_kind < 92)
            cur_time = cur_time + $urandom_range(40, 70);
        else if (step_kind < 95)
            cur_time = cur_time + $urandom_range(86250, 86450);
        else if (step_kind < 97)
            cur_time = $urandom;
        else
            cur_time = cur_time - $urandom_range(1, 100);
        r.now  = ($urandom_range(0, 99) < 3) ? dwql_pkg::TIME_W'($urandom) : cur_time;
        r.vip  = 1'($urandom_range(0, 1));
        r.sday = $urandom;
        r.scnt = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            r.amt = '0;
        else if (pick < 10)
            r.amt = '1;
        else if (pick < 22)
            r.amt = dwql_pkg::AMT_W'($urandom);
        else
            r.amt = dwql_pkg::AMT_W'($urandom_range(0, amt_hi));
        pick = $urandom_range(0, 99);
        if (pick < 22)
            r.cmd = dwql_pkg::CMD_TICK;
        else if (pick < 50)
            r.cmd = dwql_pkg::CMD_REQ_NORM;
        else if (pick < 74)
            r.cmd = dwql_pkg::CMD_REQ_ACT;
        else if (pick < 83)
            r.cmd = dwql_pkg::CMD_RESTORE;
        else if (pick < 90)
        begin
            r.cmd = dwql_pkg::CMD_SET_DAILY;
            if ($urandom_range(0, 1))
                r.sday = cur_time - $urandom_range(0, 90000);
            if ($urandom_range(0, 1))
                r.scnt = $urandom_range(0, ledger.day_limit + 10);
        end
        else if (pick < 95)
            r.cmd = dwql_pkg::CMD_REINIT;
        else
            r.cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
    endtask

    // One register setting followed by a stream of random items
    task automatic run_phase(input logic [dwql_pkg::CNT_W-1:0] dcap, mcap, acap, ps, pe,
                             input int unsigned n, input int unsigned idle_pct,
                             input bit with_hold);
        quota_req_t                 r;
        logic [dwql_pkg::CNT_W-1:0] top_cap;
        settle();
        stall_pct     = idle_pct;
        send_idle_pct = idle_pct;
        configure(dcap, mcap, acap, ps, pe);
        top_cap = (mcap > acap) ? mcap : acap;
        top_cap = dwql_pkg::CNT_W'(top_cap / 3);
        amt_hi  = (top_cap > dwql_pkg::CNT_W'(16'hFFFF)) ? '1
                : ((top_cap == '0) ? 16'd1 : top_cap[dwql_pkg::AMT_W-1:0]);
        // start from a clean state so grants actually happen
        send_dir(dwql_pkg::CMD_REINIT, cur_time, '0, 1'b0, $urandom, $urandom);
        for (int unsigned i = 1; i < n; i++)
        begin
            gen_req(r);
            send_item(r);
            if (with_hold && i == 40)
                long_hold = 1;
        end
    endtask

    // Main sequence
    initial
    begin
        ledger         = new;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        cmd            = '0;
        now_time       = '0;
        amount         = '0;
        vip            = 1'b0;
        saved_day_time = '0;
        saved_count    = '0;
        cur_time       = '0;
        amt_hi         = 16'd1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: small caps, pause window 3600..7200
        send_idle_pct = 20;
        stall_pct     = 20;
        configure(24'd1000, 24'd300, 24'd200, 24'd3600, 24'd7200);
        send_dir(dwql_pkg::CMD_TICK,     32'd0,    16'd0,   1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_REINIT,   32'd1000, 16'd0,   1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_REQ_NORM, 32'd1001, 16'd100, 1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_REQ_NORM, 32'd1002, 16'd300, 1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_REQ_NORM, 32'd1003, 16'd0,   1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_REQ_ACT,  32'd1004, 16'd10,  1'b1, '0, '0);
        // minute gap is exclusive: 50 s does not refill, 51 s does
        send_dir(dwql_pkg::CMD_TICK,     32'd1050, 16'd0,   1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_TICK,     32'd1051, 16'd0,   1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_REQ_ACT,  32'd1052, 16'd200, 1'b1, '0, '0);
        send_dir(dwql_pkg::CMD_REQ_ACT,  32'd1053, 16'd1,   1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_REQ_ACT,  32'd1054, 16'd0,   1'b1, '0, '0);
        send_dir(dwql_pkg::CMD_RESTORE,  32'd1055, 16'hFFFF, 1'b0, '0, '0);
        // saved point above the cap is clamped
        send_dir(dwql_pkg::CMD_SET_DAILY, 32'd1056, 16'd0, 1'b0, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_dir(dwql_pkg::CMD_SET_DAILY, 32'd1057, 16'd0, 1'b0, 32'hFFFF_FF00, 32'd5);
        // day window elapsed across the 32-bit wrap
        send_dir(dwql_pkg::CMD_TICK, 32'hFFFF_FF00 + 32'd86300, 16'd0, 1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_TICK, 32'hFFFF_FF00 + 32'd86301, 16'd0, 1'b0, '0, '0);
        // pause edges are outside, one second in is inside
        send_dir(CMD_SPARE_A,            32'd435600, 16'd0,    1'b1, '1, '1);
        send_dir(CMD_SPARE_B,            32'd3601,   16'hFFFF, 1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_TICK,     32'd7199,   16'd0,    1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_TICK,     32'd7200,   16'd0,    1'b0, '0, '0);
        send_dir(dwql_pkg::CMD_REQ_NORM, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '1, '1);
        cur_time = 32'd2000000;

        // Random phases over several register settings
        run_phase('0, '0, '0, '0, '0, 200, 30, 1'b0);
        run_phase(dwql_pkg::CNT_MAX, dwql_pkg::CNT_MAX, dwql_pkg::CNT_MAX,
                  24'd86399, 24'd0, 240, 20, 1'b1);
        run_phase(dwql_pkg::CNT_W'($urandom_range(5000, 200000)),
                  dwql_pkg::CNT_W'($urandom_range(500, 20000)),
                  dwql_pkg::CNT_W'($urandom_range(500, 20000)),
                  dwql_pkg::CNT_W'($urandom_range(0, 40000)),
                  dwql_pkg::CNT_W'($urandom_range(40001, 86399)), 240, 40, 1'b0);
        run_phase(dwql_pkg::CNT_W'($urandom), dwql_pkg::CNT_W'($urandom),
                  dwql_pkg::CNT_W'($urandom), dwql_pkg::CNT_W'($urandom),
                  dwql_pkg::CNT_W'($urandom), 240, 10, 1'b0);
        run_phase(dwql_pkg::CNT_W'($urandom_range(1, 3000)),
                  dwql_pkg::CNT_W'($urandom_range(1, 3000)),
                  dwql_pkg::CNT_W'($urandom_range(1, 3000)),
                  dwql_pkg::CNT_W'($urandom_range(50000, 86399)),
                  dwql_pkg::CNT_W'($urandom_range(0, 49999)), 240, 25, 1'b0);
        // last stretch runs flat out on both sides
        run_phase(dwql_pkg::CNT_W'($urandom_range(1000, 100000)),
                  dwql_pkg::CNT_W'($urandom_range(100, 10000)),
                  dwql_pkg::CNT_W'($urandom_range(100, 10000)),
                  24'd12345, 24'd12345, 250, 0, 1'b0);
        settle();
        repeat (8) @(negedge clk);

        $display("Run covered %0d requests over seven register settings: %0d results checked,",
                 items_sent, ledger.checked);
        $display("%0d non-zero grants, one long output hold-off, %0d mismatches.",
                 ledger.grants, ledger.errors);
        if (ledger.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
